/* hdl/dcc_pkg.sv */
// Shared constants, types and codes for the dual coulomb counter.
`timescale 1ns / 1ps

package dcc_pkg;

  // Field and state widths
  localparam int unsigned CUR_W   = 24;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned FULL_W  = 46;
  localparam int unsigned TICK_W  = 24;
  localparam int unsigned REP_W   = 21;
  localparam int unsigned SOC_W   = 10;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned REM_W   = FULL_W + FRAC_W;
  localparam int unsigned PART_W  = 51;
  localparam int unsigned SUM_W   = CUR_W + 1;
  localparam int unsigned DEC_W   = SUM_W + 3;

  // Shared multiplier operand widths
  localparam int unsigned MA_W    = SUM_W + 1;
  localparam int unsigned MB_W    = TICK_W + 1;
  localparam int unsigned PROD_W  = MA_W + MB_W;

  // Divide by ten: multiply by ceil(2^27 / 10), exact for magnitudes below 2^26
  localparam int unsigned          RECIP_SHIFT = 27;
  localparam logic [TICK_W-1:0]    RECIP_10    = TICK_W'(13421773);
  localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'(5);

  // Pulse partial flush threshold: 1000 mA*ms in fixed point
  localparam logic signed [PART_W-1:0] FLUSH_LIM = PART_W'(64'd1000 << FRAC_W);

  // Times 2000 as 2048 - 32 - 16
  localparam int unsigned K2000_SH_A = 11;
  localparam int unsigned K2000_SH_B = 5;
  localparam int unsigned K2000_SH_C = 4;

  localparam logic [SOC_W-1:0] SOC_FULL    = SOC_W'(1000);
  localparam logic [SOC_W-1:0] FULL_THRESH = SOC_W'(995);

  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SOC_W - 1);

  // Reset values of the configuration registers
  localparam logic [FULL_W-1:0] FULL_RESET = FULL_W'(64'd3600000000);
  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(65536);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICK    = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_PULSE       = 2'd0,
    KIND_FILTER      = 2'd1,
    KIND_LOAD_PULSE  = 2'd2,
    KIND_LOAD_FILTER = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_P_ACC,
    ST_P_CHK,
    ST_SUB,
    ST_CLAMP,
    ST_LOAD,
    ST_SOC_CMP,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_DIV,
    ST_OUT
  } state_e;

  // Request to the shared adder
  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             sub;
    logic             cin;
  } alu_req_t;

endpackage

/* hdl/dual_coulomb_counter_soc.sv */
// Top level: two coulomb counters with a shared sequencer, adder and multiplier.
`timescale 1ns / 1ps

// Usage
// Input channel: in_valid_i / in_stall_o with kind_i, current_sample_i and
// load_value_i. A transfer happens on a clock edge with valid high and stall low.
// Kind 0 and 1 are pulse and filter current samples, 2 and 3 preset the
// remaining charge of the pulse or filter channel.
// Output channel: out_valid_o / out_stall_i, one result per input item.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 is full capacity, index 1 the pulse tick in ms Q8.16. Write only
// while the block is idle; other indexes are dropped.
// Timing: a new item is taken only when the sequencer is idle, once the last
// result is in the output register. The permille value comes from a ten-step
// restoring divide, one quotient bit per cycle through the shared 64-bit adder;
// the times-2000 scaling and its rounding add take three adder passes. A charge
// at or above full capacity, or a zero capacity, skips the divide.
// Reset clears both charges, the pulse partial and the previous currents, and
// loads the capacity and tick reset values.
// While the receiver stalls, the finished result holds in the output register;
// the next item may still be transferred and is worked on, but its result
// waits until the output register is free.

module dual_coulomb_counter_soc (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,

  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             kind_i,
  input  logic signed [dcc_pkg::CUR_W-1:0]       current_sample_i,
  input  logic [dcc_pkg::FULL_W-1:0]             load_value_i,

  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   channel_o,
  output logic [dcc_pkg::FULL_W-1:0]             remaining_charge_o,
  output logic [dcc_pkg::SOC_W-1:0]              soc_permille_o,
  output logic                                   full_flag_o,
  output logic signed [dcc_pkg::REP_W-1:0]       reported_current_o,

  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dcc_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [dcc_pkg::FULL_W-1:0]             cfg_data_i
);

  // Sequencer
  dcc_pkg::state_e state_q, state_d;

  // Configuration
  logic [dcc_pkg::FULL_W-1:0] full_q;
  logic [dcc_pkg::TICK_W-1:0] tick_q;

  // Counter state
  logic [dcc_pkg::REM_W-1:0]         prem_q, prem_d;
  logic [dcc_pkg::REM_W-1:0]         frem_q, frem_d;
  logic signed [dcc_pkg::PART_W-1:0] ppart_q, ppart_d;
  logic signed [dcc_pkg::CUR_W-1:0]  pprev_q, pprev_d;
  logic signed [dcc_pkg::CUR_W-1:0]  fprev_q, fprev_d;

  // Item and work registers
  dcc_pkg::kind_e                    kind_q;
  logic signed [dcc_pkg::CUR_W-1:0]  cur_q;
  logic [dcc_pkg::FULL_W-1:0]        load_q;
  logic [dcc_pkg::ACC_W-1:0]         acc_q, acc_d;
  logic [dcc_pkg::ACC_W-1:0]         dvs_q, dvs_d;
  logic [dcc_pkg::SOC_W-1:0]         quot_q, quot_d;
  logic [dcc_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [dcc_pkg::FULL_W-1:0]        res_rem_q, res_rem_d;
  logic signed [dcc_pkg::REP_W-1:0]  rep_q, rep_d;

  // Output register
  logic                              out_valid_q, out_valid_d;
  logic                              channel_q;
  logic [dcc_pkg::FULL_W-1:0]        out_rem_q;
  logic [dcc_pkg::SOC_W-1:0]         out_soc_q;
  logic                              out_full_q;
  logic signed [dcc_pkg::REP_W-1:0]  out_rep_q;

  // Shared units
  dcc_pkg::alu_req_t                 alu_req;
  logic [dcc_pkg::ACC_W-1:0]         alu_y;
  logic                              alu_neg;
  logic                              mul_en;
  logic signed [dcc_pkg::MA_W-1:0]   mul_a;
  logic signed [dcc_pkg::MB_W-1:0]   mul_b;
  logic signed [dcc_pkg::PROD_W-1:0] prod;

  // Helpers
  logic                              in_xfer;
  logic                              out_free;
  logic                              out_load;
  logic                              chan;
  logic                              is_pulse;
  logic                              flush;
  logic signed [dcc_pkg::SUM_W-1:0]  pulse_sum;
  logic signed [dcc_pkg::SUM_W-1:0]  filt_sum;
  logic signed [dcc_pkg::DEC_W-1:0]  dec5;
  logic signed [dcc_pkg::ACC_W-1:0]  dec_q64;
  logic signed [dcc_pkg::SUM_W-1:0]  rep_x;
  logic                              rep_neg;
  logic [dcc_pkg::SUM_W-1:0]         rep_mag;
  logic [dcc_pkg::REP_W-1:0]         rep_div;
  logic signed [dcc_pkg::PROD_W-1:0] prod_half;
  logic [dcc_pkg::REM_W-1:0]         rem_sel;
  logic [dcc_pkg::REM_W-1:0]         full_fx;
  logic [dcc_pkg::REM_W-1:0]         clamped;
  logic [dcc_pkg::FULL_W-1:0]        load_sat;

  dcc_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_y)
  );

  dcc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Handshakes
  assign in_stall_o  = (state_q != dcc_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == dcc_pkg::ST_OUT) && out_free;

  // Item decode and datapath helpers
  always_comb begin
    chan      = (kind_q == dcc_pkg::KIND_FILTER) || (kind_q == dcc_pkg::KIND_LOAD_FILTER);
    is_pulse  = (kind_q == dcc_pkg::KIND_PULSE);
    pulse_sum = dcc_pkg::SUM_W'(cur_q) + dcc_pkg::SUM_W'(pprev_q);
    filt_sum  = dcc_pkg::SUM_W'(cur_q) + dcc_pkg::SUM_W'(fprev_q);
    dec5      = (dcc_pkg::DEC_W'(filt_sum) <<< 2) + dcc_pkg::DEC_W'(filt_sum);
    dec_q64   = dcc_pkg::ACC_W'(dec5) <<< dcc_pkg::FRAC_W;
    rep_x     = dcc_pkg::SUM_W'(cur_q) + dcc_pkg::ROUND_ADD;
    rep_neg   = rep_x[dcc_pkg::SUM_W-1];
    rep_mag   = rep_neg ? dcc_pkg::SUM_W'(-rep_x) : dcc_pkg::SUM_W'(rep_x);
    rep_div   = prod[dcc_pkg::RECIP_SHIFT +: dcc_pkg::REP_W];
    prod_half = prod >>> 1;
    flush     = (ppart_q > dcc_pkg::FLUSH_LIM) || (ppart_q < -dcc_pkg::FLUSH_LIM);
    rem_sel   = chan ? frem_q : prem_q;
    full_fx   = {full_q, dcc_pkg::FRAC_W'(0)};
  end

  // Adder sign, load saturation and clamp
  always_comb begin
    alu_neg  = alu_y[dcc_pkg::ACC_W-1];
    load_sat = alu_neg ? full_q : load_q;
    if (acc_q[dcc_pkg::ACC_W-1]) begin
      clamped = '0;
    end else if (alu_neg) begin
      clamped = full_fx;
    end else begin
      clamped = acc_q[dcc_pkg::REM_W-1:0];
    end
  end

  // Multiplier operands: trapezoid product or divide-by-ten reciprocal
  always_comb begin
    mul_en = (state_q == dcc_pkg::ST_MUL);
    if (is_pulse) begin
      mul_a = dcc_pkg::MA_W'(pulse_sum);
      mul_b = $signed({1'b0, tick_q});
    end else begin
      mul_a = $signed({1'b0, rep_mag});
      mul_b = $signed({1'b0, dcc_pkg::RECIP_10});
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dcc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (kind_i[1]) begin
            state_d = dcc_pkg::ST_LOAD;
          end else begin
            state_d = dcc_pkg::ST_MUL;
          end
        end
      end
      dcc_pkg::ST_MUL:     state_d = is_pulse ? dcc_pkg::ST_P_ACC : dcc_pkg::ST_SUB;
      dcc_pkg::ST_P_ACC:   state_d = dcc_pkg::ST_P_CHK;
      dcc_pkg::ST_P_CHK:   state_d = flush ? dcc_pkg::ST_SUB : dcc_pkg::ST_SOC_CMP;
      dcc_pkg::ST_SUB:     state_d = dcc_pkg::ST_CLAMP;
      dcc_pkg::ST_CLAMP:   state_d = dcc_pkg::ST_SOC_CMP;
      dcc_pkg::ST_LOAD:    state_d = dcc_pkg::ST_SOC_CMP;
      dcc_pkg::ST_SOC_CMP: begin
        if ((full_q == '0) || !alu_neg) begin
          state_d = dcc_pkg::ST_OUT;
        end else begin
          state_d = dcc_pkg::ST_N1;
        end
      end
      dcc_pkg::ST_N1:      state_d = dcc_pkg::ST_N2;
      dcc_pkg::ST_N2:      state_d = dcc_pkg::ST_N3;
      dcc_pkg::ST_N3:      state_d = dcc_pkg::ST_DIV;
      dcc_pkg::ST_DIV:     state_d = (cnt_q == '0) ? dcc_pkg::ST_OUT : dcc_pkg::ST_DIV;
      dcc_pkg::ST_OUT:     state_d = out_free ? dcc_pkg::ST_IDLE : dcc_pkg::ST_OUT;
      default:             state_d = dcc_pkg::ST_IDLE;
    endcase
  end

  // Adder requests for each step
  always_comb begin
    alu_req = '0;
    unique case (state_q)
      dcc_pkg::ST_P_ACC: begin
        // Add half the product, rounded toward zero, to the partial
        alu_req.a   = dcc_pkg::ACC_W'(ppart_q);
        alu_req.b   = dcc_pkg::ACC_W'(prod_half);
        alu_req.cin = prod[dcc_pkg::PROD_W-1] & prod[0];
      end
      dcc_pkg::ST_SUB: begin
        alu_req.sub = 1'b1;
        if (is_pulse) begin
          // Flush the partial into the remaining charge
          alu_req.a = dcc_pkg::ACC_W'(prem_q);
          alu_req.b = dcc_pkg::ACC_W'(ppart_q);
        end else begin
          alu_req.a = dcc_pkg::ACC_W'(frem_q);
          alu_req.b = dec_q64;
        end
      end
      dcc_pkg::ST_CLAMP: begin
        // Compare against full capacity
        alu_req.a   = dcc_pkg::ACC_W'(full_fx);
        alu_req.b   = acc_q;
        alu_req.sub = 1'b1;
      end
      dcc_pkg::ST_LOAD: begin
        alu_req.a   = dcc_pkg::ACC_W'(full_q);
        alu_req.b   = dcc_pkg::ACC_W'(load_q);
        alu_req.sub = 1'b1;
      end
      dcc_pkg::ST_SOC_CMP: begin
        alu_req.a   = dcc_pkg::ACC_W'(rem_sel[dcc_pkg::REM_W-1:dcc_pkg::FRAC_W]);
        alu_req.b   = dcc_pkg::ACC_W'(full_q);
        alu_req.sub = 1'b1;
      end
      dcc_pkg::ST_N1: begin
        alu_req.a   = dcc_pkg::ACC_W'(res_rem_q) << dcc_pkg::K2000_SH_A;
        alu_req.b   = dcc_pkg::ACC_W'(res_rem_q) << dcc_pkg::K2000_SH_B;
        alu_req.sub = 1'b1;
      end
      dcc_pkg::ST_N2: begin
        alu_req.a   = acc_q;
        alu_req.b   = dcc_pkg::ACC_W'(res_rem_q) << dcc_pkg::K2000_SH_C;
        alu_req.sub = 1'b1;
      end
      dcc_pkg::ST_N3: begin
        // Add full for round half up
        alu_req.a = acc_q;
        alu_req.b = dcc_pkg::ACC_W'(full_q);
      end
      dcc_pkg::ST_DIV: begin
        alu_req.a   = acc_q;
        alu_req.b   = dvs_q;
        alu_req.sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Step outputs: register updates
  always_comb begin
    prem_d    = prem_q;
    frem_d    = frem_q;
    ppart_d   = ppart_q;
    pprev_d   = pprev_q;
    fprev_d   = fprev_q;
    acc_d     = acc_q;
    dvs_d     = dvs_q;
    quot_d    = quot_q;
    cnt_d     = cnt_q;
    res_rem_d = res_rem_q;
    rep_d     = rep_q;
    unique case (state_q)
      dcc_pkg::ST_P_ACC: begin
        ppart_d = alu_y[dcc_pkg::PART_W-1:0];
        pprev_d = cur_q;
      end
      dcc_pkg::ST_SUB: begin
        if (is_pulse) begin
          ppart_d = '0;
        end else begin
          fprev_d = cur_q;
          rep_d   = rep_neg ? dcc_pkg::REP_W'(-$signed(rep_div)) : $signed(rep_div);
        end
        acc_d = alu_y;
      end
      dcc_pkg::ST_CLAMP: begin
        // Clamp to the range zero to full
        if (chan) begin
          frem_d = clamped;
        end else begin
          prem_d = clamped;
        end
      end
      dcc_pkg::ST_LOAD: begin
        // Saturate the preset at full capacity
        if (chan) begin
          frem_d = {load_sat, dcc_pkg::FRAC_W'(0)};
        end else begin
          prem_d = {load_sat, dcc_pkg::FRAC_W'(0)};
        end
      end
      dcc_pkg::ST_SOC_CMP: begin
        res_rem_d = rem_sel[dcc_pkg::REM_W-1:dcc_pkg::FRAC_W];
        if (full_q == '0) begin
          quot_d = '0;
        end else if (!alu_neg) begin
          quot_d = dcc_pkg::SOC_FULL;
        end
      end
      dcc_pkg::ST_N1: begin
        acc_d = alu_y;
      end
      dcc_pkg::ST_N2: begin
        acc_d = alu_y;
      end
      dcc_pkg::ST_N3: begin
        // Divisor starts at 2 * full << 9
        acc_d  = alu_y;
        dvs_d  = dcc_pkg::ACC_W'(full_q) << dcc_pkg::SOC_W;
        cnt_d  = dcc_pkg::DIV_LAST;
        quot_d = '0;
      end
      dcc_pkg::ST_DIV: begin
        // One restoring step per cycle
        if (!alu_neg) begin
          acc_d = alu_y;
        end
        quot_d = {quot_q[dcc_pkg::SOC_W-2:0], !alu_neg};
        dvs_d  = dvs_q >> 1;
        cnt_d  = cnt_q - dcc_pkg::CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Output valid: set on load, drop on transfer
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  // Control and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      prem_q      <= '0;
      frem_q      <= '0;
      ppart_q     <= '0;
      pprev_q     <= '0;
      fprev_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      prem_q      <= prem_d;
      frem_q      <= frem_d;
      ppart_q     <= ppart_d;
      pprev_q     <= pprev_d;
      fprev_q     <= fprev_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= dcc_pkg::FULL_RESET;
      tick_q <= dcc_pkg::TICK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        dcc_pkg::CFG_FULL_CAPACITY: full_q <= cfg_data_i;
        dcc_pkg::CFG_PULSE_TICK:    tick_q <= cfg_data_i[dcc_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Item capture and work registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= dcc_pkg::kind_e'(kind_i);
      cur_q  <= current_sample_i;
      load_q <= load_value_i;
    end
    acc_q     <= acc_d;
    dvs_q     <= dvs_d;
    quot_q    <= quot_d;
    cnt_q     <= cnt_d;
    res_rem_q <= res_rem_d;
    rep_q     <= rep_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      channel_q  <= chan;
      out_rem_q  <= res_rem_q;
      out_soc_q  <= quot_q;
      out_full_q <= (quot_q > dcc_pkg::FULL_THRESH);
      out_rep_q  <= (kind_q == dcc_pkg::KIND_FILTER) ? rep_q : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign channel_o          = channel_q;
  assign remaining_charge_o = out_rem_q;
  assign soc_permille_o     = out_soc_q;
  assign full_flag_o        = out_full_q;
  assign reported_current_o = out_rep_q;

endmodule

/* hdl/dcc_alu.sv */
// Shared 64-bit add/subtract unit used by the arithmetic steps of the sequencer.
`timescale 1ns / 1ps

module dcc_alu (
  input  dcc_pkg::alu_req_t             req_i,
  output logic [dcc_pkg::ACC_W-1:0]     sum_o
);

  logic [dcc_pkg::ACC_W-1:0] b_eff;
  logic                      carry;

  // Invert b and force the carry for subtraction
  always_comb begin
    b_eff = req_i.sub ? ~req_i.b : req_i.b;
    carry = req_i.sub ? 1'b1 : req_i.cin;
  end

  assign sum_o = req_i.a + b_eff + dcc_pkg::ACC_W'(carry);

endmodule

/* hdl/dcc_mul.sv */
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module dcc_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [dcc_pkg::MA_W-1:0]     a_i,
  input  logic signed [dcc_pkg::MB_W-1:0]     b_i,
  output logic signed [dcc_pkg::PROD_W-1:0]   prod_o
);

  logic signed [dcc_pkg::PROD_W-1:0] prod_q;

  // Capture the product when the sequencer asks for it
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= dcc_pkg::PROD_W'(a_i) * dcc_pkg::PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule
